[src/chbd_pkg.sv]
// Shared types, constants and helper functions for the chunked body decoder.
package chbd_pkg;

    // Width of the chunk size, the byte counter and the hex accumulator.
    localparam int SIZE_BITS = 32;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Framing characters.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;

    // One result item.
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } result_t;

    // Hex digit decode: bit 4 set means the byte is a hex digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                t = c - CH_ZERO;
                hex_decode = {1'b1, t[3:0]};
            end else if (c >= CH_LC_A && c <= CH_LC_F) begin
                t = c - CH_LC_A + 8'd10;
                hex_decode = {1'b1, t[3:0]};
            end else if (c >= CH_UC_A && c <= CH_UC_F) begin
                t = c - CH_UC_A + 8'd10;
                hex_decode = {1'b1, t[3:0]};
            end else begin
                hex_decode = 5'd0;
            end
        end
    endfunction

endpackage

[src/chbd_step.sv]
// Decoder state and the per-item update logic for header and data modes.
module chbd_step
    import chbd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic [7:0]   item_byte,
    output logic         res_valid,
    output result_t      res
);

    localparam logic [1:0] PH_SPACES = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    logic                 data_mode_reg, data_mode_next;
    logic [SIZE_BITS-1:0] chunk_len_reg, chunk_len_next;
    logic [SIZE_BITS-1:0] passed_reg, passed_next;
    logic [SIZE_BITS-1:0] acc_reg, acc_next;
    logic [1:0]           phase_reg, phase_next;
    logic [1:0]           line_sat_reg, line_sat_next;
    logic                 last_cr_reg, last_cr_next;

    logic                 produce;
    logic [4:0]           hex;
    logic [SIZE_BITS-1:0] passed_inc;

    assign hex        = hex_decode(item_byte);
    assign passed_inc = passed_reg + {{(SIZE_BITS-1){1'b0}}, 1'b1};

    // Next state and result for the item in the input register.
    always_comb
    begin
        data_mode_next = data_mode_reg;
        chunk_len_next = chunk_len_reg;
        passed_next    = passed_reg;
        acc_next       = acc_reg;
        phase_next     = phase_reg;
        line_sat_next  = line_sat_reg;
        last_cr_next   = last_cr_reg;
        produce        = 1'b0;
        res.data       = 8'd0;
        res.kind       = KIND_PAYLOAD;
        priority if (data_mode_reg)
        begin
            produce     = 1'b1;
            res.data    = item_byte;
            passed_next = passed_inc;
            if (passed_inc == chunk_len_reg)
            begin
                data_mode_next = 1'b0;
            end
        end
        else if (item_byte == CH_NUL)
        begin
            // A NUL in a header line reports an error and changes nothing.
            produce  = 1'b1;
            res.kind = KIND_ERROR;
        end
        else if (item_byte != CH_LF)
        begin
            // Gather size digits after leading spaces.
            if (phase_reg == PH_SPACES && item_byte == CH_SPACE)
            begin
                phase_next = phase_reg;
            end
            else if ((phase_reg == PH_SPACES || phase_reg == PH_DIGITS) && hex[4])
            begin
                acc_next   = {acc_reg[SIZE_BITS-5:0], hex[3:0]};
                phase_next = PH_DIGITS;
            end
            else
            begin
                phase_next = PH_DONE;
            end
            if (line_sat_reg < 2'd2)
            begin
                line_sat_next = line_sat_reg + 2'd1;
            end
            last_cr_next = (item_byte == CH_CR);
        end
        else
        begin
            // End of line: either a chunk tail or a size line.
            passed_next   = '0;
            acc_next      = '0;
            phase_next    = PH_SPACES;
            line_sat_next = 2'd0;
            last_cr_next  = 1'b0;
            if (line_sat_reg == 2'd0 || (line_sat_reg == 2'd1 && last_cr_reg))
            begin
                chunk_len_next = '0;
            end
            else
            begin
                chunk_len_next = acc_reg;
                if (acc_reg == '0)
                begin
                    produce  = 1'b1;
                    res.kind = KIND_END;
                end
                else
                begin
                    data_mode_next = 1'b1;
                end
            end
        end
    end

    assign res_valid = fire && produce;

    // State registers advance once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_mode_reg <= 1'b0;
            chunk_len_reg <= '0;
            passed_reg    <= '0;
            acc_reg       <= '0;
            phase_reg     <= PH_SPACES;
            line_sat_reg  <= 2'd0;
            last_cr_reg   <= 1'b0;
        end
        else if (fire)
        begin
            data_mode_reg <= data_mode_next;
            chunk_len_reg <= chunk_len_next;
            passed_reg    <= passed_next;
            acc_reg       <= acc_next;
            phase_reg     <= phase_next;
            line_sat_reg  <= line_sat_next;
            last_cr_reg   <= last_cr_next;
        end
    end

endmodule

[src/chbd_out_reg.sv]
// Result register that holds one item until the output side takes it.
module chbd_out_reg
    import chbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_valid,
    input  result_t   res,
    output logic      load,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   out_res
);

    logic    valid_reg;
    result_t res_reg;

    // The register may take a new result when empty or being emptied.
    assign load      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= res_valid;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

[src/http_chunked_body_decoder_top.sv]
// Top level of the HTTP chunked body decoder: input register, step logic, result register.
//
//   Channel | Signals                      | Role
//   --------+------------------------------+-----------------------------------
//   input   | in_valid, in_ready, in_byte  | raw chunked body, one byte an item
//   output  | out_valid, out_ready,        | payload byte, end of body or error
//           | out_byte, kind               |
//
// One item per cycle sustained while results are taken; an item's result is held in the
// input register and then in the result register around the step logic before it is
// presented. A byte that causes no result still takes its slot in the input register.
// Reset is asynchronous, active low, and puts the decoder in header mode with all
// counters cleared. While a result waits with out_ready low the step logic stalls, even
// for bytes that cause no result; an empty input register still takes one more item
// before in_ready drops.
module http_chunked_body_decoder_top
    import chbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] kind
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_free;
    logic       fire;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    // The held item is processed once the result register can take its result.
    assign fire     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
        end
    end

    chbd_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    chbd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .load      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign out_byte = out_res.data;
    assign kind     = out_res.kind;

`ifndef SYNTHESIS
    // Only the three defined result kinds ever leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_PAYLOAD || kind == KIND_END || kind == KIND_ERROR))
        else $error("undefined result kind");

    // Framing results carry a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_PAYLOAD) |-> (out_byte == 8'd0))
        else $error("framing result with nonzero byte");

    // A held input item that cannot advance is kept, not dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input item lost");
`endif

endmodule

[verif/tb.sv]
// Self-checking testbench for the HTTP chunked body decoder, driven with framed bodies and noise.
module tb;
    import chbd_pkg::*;

    localparam int CYCLE_LIMIT  = 40000;
    localparam int BODY_ITEMS   = 875;
    localparam int DRAIN_CYCLES = 10;
    localparam int GAP_PERCENT  = 12;
    localparam int QUIET_FROM   = 300;
    localparam int QUIET_UNTIL  = 700;
    localparam int MAX_PRINTED  = 40;

    // Phases of the size parse on a header line.
    localparam logic [1:0] PH_SPACES = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] FRAMING_BYTES [5] = '{CH_NUL, CH_LF, CH_CR, CH_SPACE, CH_ZERO};

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic [1:0] kind;

    // Decoder state as the testbench tracks it, starting from the reset values.
    logic                 hdr_data_mode = 1'b0;
    logic [SIZE_BITS-1:0] hdr_chunk_len = '0;
    logic [SIZE_BITS-1:0] hdr_passed    = '0;
    logic [SIZE_BITS-1:0] hdr_size_acc  = '0;
    logic [1:0]           hdr_phase     = PH_SPACES;
    logic [1:0]           hdr_line_len  = 2'd0;
    logic                 hdr_last_cr   = 1'b0;

    logic [7:0] body_bytes[$];
    result_t    decoded_items[$];

    int cycle_count    = 0;
    int items_total    = 0;
    int bytes_accepted = 0;
    int mismatches     = 0;
    int seen_payload   = 0;
    int seen_end       = 0;
    int seen_error     = 0;

    http_chunked_body_decoder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .kind      (kind)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Returns the value of a hex digit, or -1 for any other byte.
    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= CH_LC_A && c <= CH_LC_F)
            return int'(c - CH_LC_A) + 10;
        if (c >= CH_UC_A && c <= CH_UC_F)
            return int'(c - CH_UC_A) + 10;
        return -1;
    endfunction

    // Advances the tracked decoder state by one byte and queues any result it causes.
    task automatic decode_byte(input logic [7:0] c);
        int      digit;
        result_t r;
        digit  = hex_digit_value(c);
        r.data = 8'h00;
        r.kind = KIND_PAYLOAD;
        if (hdr_data_mode)
        begin
            r.data = c;
            decoded_items.push_back(r);
            hdr_passed = hdr_passed + 1'b1;
            if (hdr_passed == hdr_chunk_len)
                hdr_data_mode = 1'b0;
        end
        else if (c == CH_NUL)
        begin
            // A NUL on a header line is reported and otherwise has no effect.
            r.kind = KIND_ERROR;
            decoded_items.push_back(r);
        end
        else if (c != CH_LF)
        begin
            if (hdr_phase == PH_SPACES && c == CH_SPACE)
            begin
                // Leading spaces are skipped.
            end
            else if (hdr_phase != PH_DONE && digit >= 0)
            begin
                hdr_size_acc = {hdr_size_acc[SIZE_BITS-5:0], 4'(digit)};
                hdr_phase    = PH_DIGITS;
            end
            else
            begin
                hdr_phase = PH_DONE;
            end
            if (hdr_line_len != 2'd2)
                hdr_line_len = hdr_line_len + 2'd1;
            hdr_last_cr = (c == CH_CR);
        end
        else
        begin
            // End of line: an empty line (after one CR) is a chunk tail.
            if (hdr_line_len == 2'd0 || (hdr_line_len == 2'd1 && hdr_last_cr))
            begin
                hdr_chunk_len = '0;
            end
            else
            begin
                hdr_chunk_len = hdr_size_acc;
                if (hdr_size_acc == '0)
                begin
                    r.kind = KIND_END;
                    decoded_items.push_back(r);
                end
                else
                begin
                    hdr_data_mode = 1'b1;
                end
            end
            hdr_passed   = '0;
            hdr_size_acc = '0;
            hdr_phase    = PH_SPACES;
            hdr_line_len = 2'd0;
            hdr_last_cr  = 1'b0;
        end
    endtask

    task automatic flag_mismatch(input string what);
        if (mismatches < MAX_PRINTED)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Each side idles at random, except in one quiet window of the run.
    function automatic bit take_gap();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_UNTIL)
            return 1'b0;
        return $urandom_range(99) < GAP_PERCENT;
    endfunction

    task automatic put(input logic [7:0] b);
        body_bytes.push_back(b);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    task automatic put_crlf();
        put(CH_CR);
        put(CH_LF);
    endtask

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_LF);
        return b;
    endfunction

    // Payload bytes lean toward framing characters now and then.
    function automatic logic [7:0] payload_byte();
        if ($urandom_range(7) == 0)
            return FRAMING_BYTES[$urandom_range(4)];
        return 8'($urandom_range(255));
    endfunction

    function automatic int digits_for(input logic [63:0] v);
        int nd;
        nd = 1;
        while (nd < 16 && (v >> (4 * nd)) != 0)
            nd++;
        return nd;
    endfunction

    // Writes the low nd nibbles of v as hex, letters in random case.
    task automatic put_hex(input logic [63:0] v, input int nd);
        logic [3:0] nib;
        for (int i = nd - 1; i >= 0; i--)
        begin
            nib = v[4*i +: 4];
            if (nib < 4'd10)
                put(CH_ZERO + nib);
            else if ($urandom_range(1) == 1)
                put(CH_UC_A + nib - 8'd10);
            else
                put(CH_LC_A + nib - 8'd10);
        end
    endtask

    // Size line: optional leading spaces, digits, optional extension, CR LF or bare LF.
    task automatic put_size_line(input logic [63:0] v, input int nd);
        int spaces;
        int extra;
        spaces = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (spaces) put(CH_SPACE);
        put_hex(v, nd);
        if ($urandom_range(4) == 0)
        begin
            put(($urandom_range(1) == 1) ? CH_SEMI : CH_SPACE);
            extra = $urandom_range(5);
            repeat (extra) put(any_but_lf());
        end
        if ($urandom_range(6) != 0)
            put(CH_CR);
        put(CH_LF);
    endtask

    function automatic int pick_size();
        int r;
        r = $urandom_range(9);
        if (r < 7)
            return $urandom_range(1, 12);
        if (r < 9)
            return $urandom_range(13, 40);
        return $urandom_range(41, 96);
    endfunction

    task automatic put_chunk(input int n);
        int r;
        // Now and then the size carries extra high digits that wrap away.
        if ($urandom_range(9) == 0)
            put_size_line({32'($urandom), 32'(n)}, 9 + $urandom_range(3));
        else
            put_size_line(64'(n), digits_for(64'(n)) +
                          (($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0));
        repeat (n) put(payload_byte());
        r = $urandom_range(19);
        if (r < 14)
            put_crlf();
        else if (r < 17)
            put(CH_LF);
    endtask

    task automatic put_body();
        int chunks;
        chunks = $urandom_range(1, 4);
        repeat (chunks) put_chunk(pick_size());
        put_size_line(64'd0, 1 + $urandom_range(2));
        if ($urandom_range(3) == 0)
        begin
            put_text("X-Sum: 1");
            put_crlf();
        end
        put_crlf();
    endtask

    // Stray lines between bodies, all of which leave the decoder in header mode.
    task automatic put_noise();
        logic [7:0] lead;
        int         extra;
        case ($urandom_range(4))
            0: put(CH_LF);
            1: put_crlf();
            2: put(CH_NUL);
            default:
            begin
                do
                    lead = 8'($urandom_range(255));
                while (hex_digit_value(lead) >= 0 || lead == CH_SPACE ||
                       lead == CH_LF || lead == CH_NUL);
                put(lead);
                extra = $urandom_range(6);
                repeat (extra) put(any_but_lf());
                put(CH_LF);
            end
        endcase
    endtask

    // Input driver: presents queued bytes, holding each one until it is taken.
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            decode_byte(in_byte);
            bytes_accepted++;
        end
        if (rst_n && (!in_valid || in_ready))
        begin
            if (body_bytes.size() != 0 && !take_gap())
            begin
                in_valid <= 1'b1;
                in_byte  <= body_bytes.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each taken result with the oldest queued one.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (out_valid && out_ready)
        begin
            if (decoded_items.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result byte %02h kind %0d", out_byte, kind));
            end
            else
            begin
                want = decoded_items.pop_front();
                if (kind !== want.kind)
                    flag_mismatch($sformatf("kind %0d, wanted %0d", kind, want.kind));
                if (out_byte !== want.data)
                    flag_mismatch($sformatf("byte %02h, wanted %02h", out_byte, want.data));
                case (want.kind)
                    KIND_PAYLOAD: seen_payload++;
                    KIND_END:     seen_end++;
                    default:      seen_error++;
                endcase
            end
        end
        if (rst_n)
            out_ready <= !take_gap();
    end

    // Watchdog on the length of the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timed out with %0d results outstanding", decoded_items.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        // Directed opening: bare LF, NUL on a header line, a space before the size,
        // NUL and 0xFF as payload, a size that stops at "0x", a line of CR CR,
        // and a size whose high digits wrap, followed by an LF as payload.
        put(CH_LF);
        put(CH_NUL);
        put(CH_SPACE);
        put_text("2");
        put_crlf();
        put(8'h00);
        put(8'hFF);
        put_text("0x1a");
        put(CH_LF);
        put(CH_CR);
        put_crlf();
        put_text("100000001");
        put(CH_LF);
        put(CH_LF);

        // Random part: mostly whole bodies, the rest stray lines.
        while (body_bytes.size() < BODY_ITEMS)
        begin
            if ($urandom_range(4) != 0)
                put_body();
            else
                put_noise();
        end
        items_total = body_bytes.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_accepted < items_total)
            @(posedge clk);
        while (decoded_items.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d body bytes; checked %0d payload bytes, %0d ends of body, %0d NUL errors",
                 items_total, seen_payload, seen_end, seen_error);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[http_chunked_body_decoder_top.f]
src/chbd_pkg.sv
src/chbd_step.sv
src/chbd_out_reg.sv
src/http_chunked_body_decoder_top.sv
verif/tb.sv
